### src/dvi_pkg.sv
// Shared types and constants for the damped velocity integrator.
// Used by dvi_lane, dvi_ctrl and damped_velocity_integrator_core; no dependencies.
package dvi_pkg;

  localparam int VEL_W     = 31;
  localparam int LIMIT_W   = 30;
  localparam int GAIN_W    = 16;
  localparam int DT_W      = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SUM_W     = VEL_W + 1;
  localparam int PRODD_W   = VEL_W + DT_W;
  localparam int COEF_W    = GAIN_W + DT_W;
  localparam int COEF_FRAC = 24;
  localparam int DECAY_W   = VEL_W + COEF_FRAC;
  localparam int DT_FRAC   = 16;

  // 0.01 and 0.0001 in Q.16, rounded up to the first excluded value
  localparam logic [SUM_W-1:0] DEADZONE    = SUM_W'(656);
  localparam logic [VEL_W-1:0] MIN_SPEED   = VEL_W'(7);
  localparam logic [DT_W-1:0]  MIN_ELAPSED = DT_W'(7);

  localparam logic [LIMIT_W-1:0] LIMIT_PITCH_RST = LIMIT_W'(43253760);
  localparam logic [LIMIT_W-1:0] LIMIT_YAW_RST   = LIMIT_W'(43253760);
  localparam logic [LIMIT_W-1:0] LIMIT_ZOOM_RST  = LIMIT_W'(524288000);
  localparam logic [GAIN_W-1:0]  DAMP_PITCH_RST  = GAIN_W'(2560);
  localparam logic [GAIN_W-1:0]  DAMP_YAW_RST    = GAIN_W'(3072);
  localparam logic [GAIN_W-1:0]  DAMP_ZOOM_RST   = GAIN_W'(2560);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIMIT_PITCH = 3'd0,
    REG_LIMIT_YAW   = 3'd1,
    REG_LIMIT_ZOOM  = 3'd2,
    REG_DAMP_PITCH  = 3'd3,
    REG_DAMP_YAW    = 3'd4,
    REG_DAMP_ZOOM   = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_IMPULSE = 1'b0,
    OP_TICK    = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_IMP,
    ST_MUL,
    ST_DEC,
    ST_UPD,
    ST_OUT
  } state_t;

  // per-phase strobes broadcast to all lanes
  typedef struct packed {
    logic imp;
    logic mul;
    logic dec;
    logic upd;
  } lane_ctl_t;

endpackage

### src/damped_velocity_integrator_core.sv
// Top level: configuration registers, input capture, three channel lanes and result register.
// Depends on dvi_pkg, dvi_lane and dvi_ctrl.
//
// Usage:
//   Input channel item_valid/item_stall carries operation, three impulses and elapsed.
//   operation impulse adds impulses to the pitch, yaw and zoom velocities; operation
//   tick advances time by elapsed and reports the per-channel deltas.
//   Output channel result_valid/result_stall carries one result beat per input beat.
//   Configuration: cfg_write with cfg_index and cfg_data, taken at once; write only
//   while the block is idle.
//   Sequence: from input capture, the single sequencer steps all lanes through the
//   impulse phase for an impulse, or two multiply stages and the velocity update for
//   a tick, then loads the result register; only then does it take the next beat.
//   The three channels run side by side in their own lanes.
//   The result sits in an output register; while the receiver stalls the held result
//   does not change and a finished item waits for the register before the next beat
//   is taken.
//   Reset clears velocities, active flags and the sequencer and loads the default limits
//   and damping gains; no clearing pass is needed.
module damped_velocity_integrator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_stall,
  input  logic                                 operation,
  input  logic signed [dvi_pkg::VEL_W-1:0]     impulse_pitch,
  input  logic signed [dvi_pkg::VEL_W-1:0]     impulse_yaw,
  input  logic signed [dvi_pkg::VEL_W-1:0]     impulse_zoom,
  input  logic [dvi_pkg::DT_W-1:0]             elapsed,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [dvi_pkg::VEL_W-1:0]     delta_pitch,
  output logic signed [dvi_pkg::VEL_W-1:0]     delta_yaw,
  output logic signed [dvi_pkg::VEL_W-1:0]     delta_zoom,
  output logic [2:0]                           moved_mask,
  output logic [2:0]                           active_mask,
  input  logic                                 cfg_write,
  input  logic [dvi_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dvi_pkg::LIMIT_W-1:0]          cfg_data
);
  import dvi_pkg::*;

  logic [LIMIT_W-1:0] limit_pitch;
  logic [LIMIT_W-1:0] limit_yaw;
  logic [LIMIT_W-1:0] limit_zoom;
  logic [GAIN_W-1:0]  damp_pitch;
  logic [GAIN_W-1:0]  damp_yaw;
  logic [GAIN_W-1:0]  damp_zoom;

  logic signed [VEL_W-1:0] imp_pitch;
  logic signed [VEL_W-1:0] imp_yaw;
  logic signed [VEL_W-1:0] imp_zoom;
  logic [DT_W-1:0]         dt;

  logic                    accept;
  logic                    load_out;
  logic                    tick_en;
  lane_ctl_t               ctl;
  logic signed [VEL_W-1:0] lane_delta [3];
  logic [2:0]              lane_moved;
  logic [2:0]              lane_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_pitch <= LIMIT_PITCH_RST;
      limit_yaw   <= LIMIT_YAW_RST;
      limit_zoom  <= LIMIT_ZOOM_RST;
      damp_pitch  <= DAMP_PITCH_RST;
      damp_yaw    <= DAMP_YAW_RST;
      damp_zoom   <= DAMP_ZOOM_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LIMIT_PITCH: limit_pitch <= cfg_data;
        REG_LIMIT_YAW:   limit_yaw   <= cfg_data;
        REG_LIMIT_ZOOM:  limit_zoom  <= cfg_data;
        REG_DAMP_PITCH:  damp_pitch  <= cfg_data[GAIN_W-1:0];
        REG_DAMP_YAW:    damp_yaw    <= cfg_data[GAIN_W-1:0];
        REG_DAMP_ZOOM:   damp_zoom   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept  = item_valid && !item_stall;
  assign tick_en = dt >= MIN_ELAPSED;

  always_ff @(posedge clk) begin
    if (accept) begin
      imp_pitch <= impulse_pitch;
      imp_yaw   <= impulse_yaw;
      imp_zoom  <= impulse_zoom;
      dt        <= elapsed;
    end
  end

  dvi_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .operation    (operation),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .item_stall   (item_stall),
    .load_out     (load_out),
    .ctl          (ctl)
  );

  dvi_lane u_lane_pitch (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .tick_en (tick_en),
    .limit   (limit_pitch),
    .gain    (damp_pitch),
    .impulse (imp_pitch),
    .dt      (dt),
    .delta   (lane_delta[0]),
    .moved   (lane_moved[0]),
    .active  (lane_active[0])
  );

  dvi_lane u_lane_yaw (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .tick_en (tick_en),
    .limit   (limit_yaw),
    .gain    (damp_yaw),
    .impulse (imp_yaw),
    .dt      (dt),
    .delta   (lane_delta[1]),
    .moved   (lane_moved[1]),
    .active  (lane_active[1])
  );

  dvi_lane u_lane_zoom (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .tick_en (tick_en),
    .limit   (limit_zoom),
    .gain    (damp_zoom),
    .impulse (imp_zoom),
    .dt      (dt),
    .delta   (lane_delta[2]),
    .moved   (lane_moved[2]),
    .active  (lane_active[2])
  );

  // result register: merges the lanes into one beat
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= load_out || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      delta_pitch <= lane_delta[0];
      delta_yaw   <= lane_delta[1];
      delta_zoom  <= lane_delta[2];
      moved_mask  <= lane_moved;
      active_mask <= lane_active;
    end
  end

endmodule

### src/dvi_lane.sv
// One velocity channel: impulse accumulation, tick delta and decay.
// Depends on dvi_pkg; sequenced by the phase strobes from dvi_ctrl.
module dvi_lane (
  input  logic                             clk,
  input  logic                             rst,
  input  dvi_pkg::lane_ctl_t               ctl,
  input  logic                             tick_en,
  input  logic [dvi_pkg::LIMIT_W-1:0]      limit,
  input  logic [dvi_pkg::GAIN_W-1:0]       gain,
  input  logic signed [dvi_pkg::VEL_W-1:0] impulse,
  input  logic [dvi_pkg::DT_W-1:0]         dt,
  output logic signed [dvi_pkg::VEL_W-1:0] delta,
  output logic                             moved,
  output logic                             active
);
  import dvi_pkg::*;

  logic signed [VEL_W-1:0] vel;
  logic                    live;
  logic                    neg;
  logic [PRODD_W-1:0]      prod_d;
  logic [COEF_W-1:0]       coef;
  logic [DECAY_W-1:0]      decay_prod;

  logic [VEL_W-1:0]        mag;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_mag;
  logic signed [SUM_W-1:0] limit_s;
  logic signed [SUM_W-1:0] clamped;
  logic [PRODD_W-1:0]      d_sum;
  logic [VEL_W-1:0]        d_round;
  logic [DECAY_W-1:0]      k_sum;
  logic [VEL_W-1:0]        k_round;
  logic [VEL_W-1:0]        new_mag;
  logic                    coef_full;

  always_comb begin
    mag     = vel[VEL_W-1] ? VEL_W'(-vel) : VEL_W'(vel);
    sum     = SUM_W'(vel) + SUM_W'(impulse);
    sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    limit_s = signed'({{(SUM_W-LIMIT_W){1'b0}}, limit});
    if (sum < -limit_s) begin
      clamped = -limit_s;
    end else if (sum > limit_s) begin
      clamped = limit_s;
    end else begin
      clamped = sum;
    end
    d_sum     = prod_d + (PRODD_W'(1) << (DT_FRAC - 1));
    d_round   = d_sum[DT_FRAC +: VEL_W];
    k_sum     = decay_prod + (DECAY_W'(1) << (COEF_FRAC - 1));
    k_round   = k_sum[COEF_FRAC +: VEL_W];
    new_mag   = mag - k_round;
    coef_full = |coef[COEF_W-1:COEF_FRAC];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel    <= '0;
      active <= 1'b0;
      live   <= 1'b0;
    end else begin
      if (ctl.imp) begin
        live <= 1'b0;
        if (impulse != '0) begin
          if (sum_mag < DEADZONE) begin
            vel    <= '0;
            active <= 1'b0;
          end else begin
            vel    <= clamped[VEL_W-1:0];
            active <= 1'b1;
          end
        end
      end
      if (ctl.mul) begin
        if (tick_en && active && (mag < MIN_SPEED)) begin
          vel    <= '0;
          active <= 1'b0;
          live   <= 1'b0;
        end else begin
          live <= tick_en && active;
        end
      end
      if (ctl.upd && live) begin
        if (coef_full) begin
          vel    <= '0;
          active <= 1'b0;
        end else begin
          vel <= neg ? signed'(VEL_W'(-new_mag)) : signed'(new_mag);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.imp) begin
      delta <= '0;
    end
    if (ctl.mul) begin
      prod_d <= PRODD_W'(mag) * PRODD_W'(dt);
      coef   <= COEF_W'(gain) * COEF_W'(dt);
      neg    <= vel[VEL_W-1];
    end
    if (ctl.dec) begin
      decay_prod <= DECAY_W'(mag) * DECAY_W'(coef[COEF_FRAC-1:0]);
      if (live) begin
        delta <= neg ? signed'(VEL_W'(-d_round)) : signed'(d_round);
      end else begin
        delta <= '0;
      end
    end
  end

  assign moved = live;

endmodule

### src/dvi_ctrl.sv
// Sequencer: takes one beat, steps the lanes through their phases, hands off a result.
// Depends on dvi_pkg.
module dvi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               operation,
  input  logic               result_valid,
  input  logic               result_stall,
  output logic               item_stall,
  output logic               load_out,
  output dvi_pkg::lane_ctl_t ctl
);
  import dvi_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = 1'b1;
    load_out   = 1'b0;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          state_next = (operation == OP_TICK) ? ST_MUL : ST_IMP;
        end
      end
      ST_IMP: begin
        ctl.imp    = 1'b1;
        state_next = ST_OUT;
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_DEC;
      end
      ST_DEC: begin
        ctl.dec    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        ctl.upd    = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!result_valid || !result_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
